@@ rtl/tpq_pkg.sv @@
// Shared types and constants for the three-level priority task queue.
// Holds request and response word layouts, request, level and status codes.
// No dependencies.
package tpq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TASK_BITS   = 16;
   localparam int LIMIT_BITS  = 8;
   localparam int LEVELS      = 3;

   localparam logic [LIMIT_BITS-1:0] STREAK_LIMIT_RESET = 8'd4;

   localparam logic [1:0] REQ_ENQUEUE = 2'd0;
   localparam logic [1:0] REQ_DEQUEUE = 2'd1;
   localparam logic [1:0] REQ_STOP    = 2'd2;

   localparam logic [1:0] LVL_HIGH    = 2'd0;
   localparam logic [1:0] LVL_NORMAL  = 2'd1;
   localparam logic [1:0] LVL_LOW     = 2'd2;

   localparam logic [2:0] ST_ENQUEUED    = 3'd0;
   localparam logic [2:0] ST_REF_STOPPED = 3'd1;
   localparam logic [2:0] ST_REF_FULL    = 3'd2;
   localparam logic [2:0] ST_GIVEN       = 3'd3;
   localparam logic [2:0] ST_EMPTY       = 3'd4;
   localparam logic [2:0] ST_STOPPED     = 3'd5;

   typedef struct packed {
      logic [1:0]           req_type;
      logic [1:0]           priority_req;
      logic [TASK_BITS-1:0] task_id;
   } req_word_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [TASK_BITS-1:0] task_id_out;
      logic [1:0]           served_priority;
   } rsp_word_type;

endpackage

@@ rtl/tpq_fifo.sv @@
// One level's handle FIFO: circular store with head and count.
// Head word is prefetched into a register, with bypass on a push to an empty queue.
// Depends on tpq_pkg.
module tpq_fifo #(
   parameter int QUEUE_DEPTH = tpq_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic                           pop,
   input  logic [tpq_pkg::TASK_BITS-1:0]  wr_data,
   output logic [tpq_pkg::TASK_BITS-1:0]  head_data,
   output logic                           empty,
   output logic                           full
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   logic [tpq_pkg::TASK_BITS-1:0] mem [QUEUE_DEPTH];
   logic [tpq_pkg::TASK_BITS-1:0] head_data_ff;
   logic [PTR_W-1:0]              head_ff, head_in, tail;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [SUM_W-1:0]              tail_sum;

   always_comb begin
      tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
      if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
         tail = PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
      end else begin
         tail = PTR_W'(tail_sum);
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (pop) begin
         if (head_ff == PTR_W'(QUEUE_DEPTH - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + PTR_W'(1);
         end
         count_in = count_ff - CNT_W'(1);
      end else if (push) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[tail] <= wr_data;
      end
   end

   // prefetch the next head word; bypass when the push lands on it
   always_ff @(posedge clock) begin
      if (push && (tail == head_in)) begin
         head_data_ff <= wr_data;
      end else begin
         head_data_ff <= mem[head_in];
      end
   end

   assign head_data = head_data_ff;
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));

endmodule

@@ rtl/three_level_priority_task_queue_unit.sv @@
// Top level of the three-level priority task queue with starvation limit.
// Holds input and result registers, the grant decision and the streak and stop state.
// Depends on tpq_pkg and tpq_fifo.
//
//   channel  direction  ports                               word
//   req      in         req_valid, req_ready, req_data      tpq_pkg::req_word_type
//   rsp      out        rsp_valid, rsp_ready, rsp_data      tpq_pkg::rsp_word_type
//   csr      in         csr_wen, csr_wdata                  high streak limit
//
// One word in and one word out per cycle while the receiver is ready; the request
// word is registered in the input register and the result word in the result register.
// The decision, one FIFO push or pop and the streak update sit in one stage.
// Reset is synchronous: FIFOs empty, streak zero, not stopped, limit four.
// A stalled result holds the stage; a new request is still taken while the
// input register is empty or moving on.
module three_level_priority_task_queue_unit #(
   parameter int QUEUE_DEPTH = tpq_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  tpq_pkg::req_word_type               req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tpq_pkg::rsp_word_type               rsp_data,
   input  logic                                csr_wen,
   input  logic [tpq_pkg::LIMIT_BITS-1:0]      csr_wdata
);

   logic                          req_vld_ff;
   tpq_pkg::req_word_type         req_word_ff;
   logic                          rsp_vld_ff;
   tpq_pkg::rsp_word_type         rsp_word_ff, rsp_word_in;
   logic [tpq_pkg::LIMIT_BITS-1:0] limit_ff;
   logic [tpq_pkg::LIMIT_BITS-1:0] streak_ff, streak_in;
   logic                          stopped_ff, stopped_in;
   logic                          advance;
   logic [1:0]                    lvl, pick;
   logic                          have;

   logic [tpq_pkg::LEVELS-1:0]    push, pop, empty, full;
   logic [tpq_pkg::TASK_BITS-1:0] head_data [tpq_pkg::LEVELS];

   assign advance   = req_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !req_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (req_ready) begin
         req_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_word_ff <= req_data;
      end
   end

   genvar g;
   generate
      for (g = 0; g < tpq_pkg::LEVELS; g++) begin : g_level
         tpq_fifo #(
            .QUEUE_DEPTH (QUEUE_DEPTH)
         ) u_fifo (
            .clock     (clock),
            .reset     (reset),
            .push      (push[g]),
            .pop       (pop[g]),
            .wr_data   (req_word_ff.task_id),
            .head_data (head_data[g]),
            .empty     (empty[g]),
            .full      (full[g])
         );
      end
   endgenerate

   // saturate the level code to low
   assign lvl = (req_word_ff.priority_req > tpq_pkg::LVL_LOW) ? tpq_pkg::LVL_LOW
                                                              : req_word_ff.priority_req;

   always_comb begin
      have      = 1'b1;
      pick      = tpq_pkg::LVL_HIGH;
      streak_in = streak_ff;
      if (!empty[tpq_pkg::LVL_HIGH]) begin
         if (streak_ff < limit_ff) begin
            streak_in = streak_ff + tpq_pkg::LIMIT_BITS'(1);
         end else if (!empty[tpq_pkg::LVL_NORMAL]) begin
            pick      = tpq_pkg::LVL_NORMAL;
            streak_in = '0;
         end
      end else if (!empty[tpq_pkg::LVL_NORMAL]) begin
         pick      = tpq_pkg::LVL_NORMAL;
         streak_in = '0;
      end else if (!empty[tpq_pkg::LVL_LOW]) begin
         pick = tpq_pkg::LVL_LOW;
      end else begin
         have = 1'b0;
      end
   end

   always_comb begin
      push        = '0;
      pop         = '0;
      stopped_in  = stopped_ff;
      rsp_word_in = '{status: tpq_pkg::ST_EMPTY, task_id_out: '0, served_priority: '0};
      case (req_word_ff.req_type)
         tpq_pkg::REQ_ENQUEUE: begin
            if (stopped_ff) begin
               rsp_word_in.status = tpq_pkg::ST_REF_STOPPED;
            end else if (full[lvl]) begin
               rsp_word_in.status = tpq_pkg::ST_REF_FULL;
            end else begin
               push[lvl]          = advance;
               rsp_word_in.status = tpq_pkg::ST_ENQUEUED;
            end
         end
         tpq_pkg::REQ_DEQUEUE: begin
            if (stopped_ff) begin
               rsp_word_in.status = tpq_pkg::ST_STOPPED;
            end else if (have) begin
               pop[pick]                   = advance;
               rsp_word_in.status          = tpq_pkg::ST_GIVEN;
               rsp_word_in.task_id_out     = head_data[pick];
               rsp_word_in.served_priority = pick;
            end
         end
         tpq_pkg::REQ_STOP: begin
            stopped_in         = 1'b1;
            rsp_word_in.status = tpq_pkg::ST_STOPPED;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         streak_ff  <= '0;
         stopped_ff <= 1'b0;
      end else if (advance) begin
         stopped_ff <= stopped_in;
         if ((req_word_ff.req_type == tpq_pkg::REQ_DEQUEUE) && !stopped_ff && have) begin
            streak_ff <= streak_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= tpq_pkg::STREAK_LIMIT_RESET;
      end else if (csr_wen) begin
         limit_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_word_ff;

endmodule

@@ verif/tpq_grant_checker.sv @@
// Checker for the three-level priority task queue: watches the request, result
// and register ports, predicts each result word and compares it field by field.
// Depends on tpq_pkg; instantiated beside the block by the testbench top.
`timescale 1ns / 100ps

module tpq_grant_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  tpq_pkg::req_word_type         req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  tpq_pkg::rsp_word_type         rsp_data,
   input  logic                          csr_wen,
   input  logic [tpq_pkg::LIMIT_BITS-1:0] csr_wdata,
   output int                            mismatch_count,
   output int                            words_pending
);

   logic [tpq_pkg::TASK_BITS-1:0]  level_store [tpq_pkg::LEVELS][tpq_pkg::QUEUE_DEPTH];
   int                             head_ptr    [tpq_pkg::LEVELS];
   int                             level_count [tpq_pkg::LEVELS];
   logic [tpq_pkg::LIMIT_BITS-1:0] streak;
   logic [tpq_pkg::LIMIT_BITS-1:0] streak_limit;
   logic                           halted;
   tpq_pkg::rsp_word_type          expected_words [$];

   function automatic tpq_pkg::rsp_word_type serve_request(input tpq_pkg::req_word_type w);
      tpq_pkg::rsp_word_type r;
      logic [1:0]            lvl;
      logic [1:0]            pick;
      bit                    found;
      int                    slot;
      r        = '0;
      r.status = tpq_pkg::ST_EMPTY;
      case (w.req_type)
         tpq_pkg::REQ_ENQUEUE: begin
            lvl = (w.priority_req > tpq_pkg::LVL_LOW) ? tpq_pkg::LVL_LOW : w.priority_req;
            if (halted) begin
               r.status = tpq_pkg::ST_REF_STOPPED;
            end else if (level_count[lvl] >= tpq_pkg::QUEUE_DEPTH) begin
               r.status = tpq_pkg::ST_REF_FULL;
            end else begin
               slot = (head_ptr[lvl] + level_count[lvl]) % tpq_pkg::QUEUE_DEPTH;
               level_store[lvl][slot] = w.task_id;
               level_count[lvl]++;
               r.status = tpq_pkg::ST_ENQUEUED;
            end
         end
         tpq_pkg::REQ_DEQUEUE: begin
            if (halted) begin
               r.status = tpq_pkg::ST_STOPPED;
            end else begin
               found = 1'b1;
               pick  = tpq_pkg::LVL_HIGH;
               if (level_count[tpq_pkg::LVL_HIGH] != 0) begin
                  if (streak < streak_limit) begin
                     streak++;
                  end else if (level_count[tpq_pkg::LVL_NORMAL] != 0) begin
                     pick   = tpq_pkg::LVL_NORMAL;
                     streak = '0;
                  end
               end else if (level_count[tpq_pkg::LVL_NORMAL] != 0) begin
                  pick   = tpq_pkg::LVL_NORMAL;
                  streak = '0;
               end else if (level_count[tpq_pkg::LVL_LOW] != 0) begin
                  pick = tpq_pkg::LVL_LOW;
               end else begin
                  found = 1'b0;
               end
               if (found) begin
                  r.task_id_out     = level_store[pick][head_ptr[pick]];
                  r.served_priority = pick;
                  r.status          = tpq_pkg::ST_GIVEN;
                  head_ptr[pick]    = (head_ptr[pick] + 1) % tpq_pkg::QUEUE_DEPTH;
                  level_count[pick]--;
               end
            end
         end
         tpq_pkg::REQ_STOP: begin
            halted   = 1'b1;
            r.status = tpq_pkg::ST_STOPPED;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic check_field(input string field, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      tpq_pkg::rsp_word_type want;
      if (reset) begin
         for (int l = 0; l < tpq_pkg::LEVELS; l++) begin
            head_ptr[l]    = 0;
            level_count[l] = 0;
         end
         streak       = '0;
         streak_limit = tpq_pkg::STREAK_LIMIT_RESET;
         halted       = 1'b0;
         expected_words.delete();
      end else begin
         if (csr_wen) streak_limit = csr_wdata;
         if (req_valid && req_ready) expected_words.push_back(serve_request(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("result word with no expectation waiting: %0h", rsp_data);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("status", want.status, rsp_data.status);
               check_field("task_id_out", want.task_id_out, rsp_data.task_id_out);
               check_field("served_priority", want.served_priority, rsp_data.served_priority);
            end
         end
      end
      words_pending = expected_words.size();
   end

endmodule

@@ verif/three_level_priority_task_queue_unit_test.sv @@
// Testbench top for the three-level priority task queue: drives directed and
// random request words, bursty sending, receiver stalls and register writes.
// Depends on tpq_pkg, the block and tpq_grant_checker, which does the comparing.
`timescale 1ns / 100ps

module three_level_priority_task_queue_unit_test;

   localparam logic [1:0] REQ_IDLE    = 2'd3;
   localparam logic [1:0] LVL_SPARE   = 2'd3;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         LONG_HOLD   = 300;
   localparam int         PHASE_WORDS = 90;

   typedef enum int {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_RHYTHM} stall_style_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   tpq_pkg::req_word_type          req_data;
   logic                           rsp_valid;
   logic                           rsp_ready;
   tpq_pkg::rsp_word_type          rsp_data;
   logic                           csr_wen;
   logic [tpq_pkg::LIMIT_BITS-1:0] csr_wdata;

   int              mismatch_count;
   int              words_pending;
   int              cycle_count = 0;
   int              burst_left  = 0;
   int              hold_left   = 0;
   int              mode_left   = 0;
   bit              long_hold_pending = 1'b0;
   stall_style_type stall_mode = STALL_NONE;

   three_level_priority_task_queue_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata)
   );

   tpq_grant_checker u_grant_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_wen        (csr_wen),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver: own stall pattern, plus a long hold-off on request
   always @(negedge clock) begin
      if (long_hold_pending) begin
         long_hold_pending = 1'b0;
         hold_left         = LONG_HOLD;
      end
      if (mode_left == 0) begin
         stall_mode = stall_style_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(20, 80);
      end else begin
         mode_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_mode)
            STALL_NONE:   rsp_ready <= 1'b1;
            STALL_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            STALL_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:      rsp_ready <= (mode_left % 3 != 0);
         endcase
      end
   end

   function automatic tpq_pkg::req_word_type make_word(input logic [1:0] kind,
                                                       input logic [1:0] lvl,
                                                       input logic [tpq_pkg::TASK_BITS-1:0] id);
      tpq_pkg::req_word_type w;
      w.req_type     = kind;
      w.priority_req = lvl;
      w.task_id      = id;
      return w;
   endfunction

   function automatic tpq_pkg::req_word_type random_word(input int enq_pct,
                                                         input logic [1:0] fav_level,
                                                         input bit allow_stop);
      tpq_pkg::req_word_type w;
      int                    roll;
      roll           = $urandom_range(0, 99);
      w.task_id      = tpq_pkg::TASK_BITS'($urandom_range(0, 65535));
      w.priority_req = ($urandom_range(0, 1) == 1) ? fav_level : 2'($urandom_range(0, 3));
      if (roll < 3)                     w.req_type = REQ_IDLE;
      else if (allow_stop && roll < 8)  w.req_type = tpq_pkg::REQ_STOP;
      else if (roll < enq_pct)          w.req_type = tpq_pkg::REQ_ENQUEUE;
      else                              w.req_type = tpq_pkg::REQ_DEQUEUE;
      return w;
   endfunction

   task automatic send_word(input tpq_pkg::req_word_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // drop valid, then wait for every expected word to come back
   task automatic drain_block();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (words_pending != 0);
   endtask

   task automatic set_limit(input logic [tpq_pkg::LIMIT_BITS-1:0] value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen   <= 1'b0;
   endtask

   initial begin
      logic [tpq_pkg::LIMIT_BITS-1:0] phase_limit;
      logic [1:0]                     fav_level;
      int                             enq_pct;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      csr_wen   = 1'b0;
      csr_wdata = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // reset limit: every level, saturated level, idle type, empty dequeue
      send_word(make_word(tpq_pkg::REQ_ENQUEUE, tpq_pkg::LVL_HIGH, 16'h0000));
      send_word(make_word(tpq_pkg::REQ_ENQUEUE, tpq_pkg::LVL_NORMAL, 16'hFFFF));
      send_word(make_word(tpq_pkg::REQ_ENQUEUE, tpq_pkg::LVL_LOW, 16'h5A5A));
      send_word(make_word(tpq_pkg::REQ_ENQUEUE, LVL_SPARE, 16'hA5A5));
      send_word(make_word(REQ_IDLE, LVL_SPARE, 16'hFFFF));
      repeat (5) send_word(make_word(tpq_pkg::REQ_DEQUEUE, tpq_pkg::LVL_HIGH, 16'h0000));
      drain_block();

      // zero limit prefers normal; then fill high past full
      set_limit(8'd0);
      send_word(make_word(tpq_pkg::REQ_ENQUEUE, tpq_pkg::LVL_HIGH, 16'h1234));
      send_word(make_word(tpq_pkg::REQ_ENQUEUE, tpq_pkg::LVL_NORMAL, 16'h4321));
      send_word(make_word(tpq_pkg::REQ_DEQUEUE, tpq_pkg::LVL_HIGH, 16'h0000));
      send_word(make_word(tpq_pkg::REQ_DEQUEUE, tpq_pkg::LVL_HIGH, 16'h0000));
      for (int i = 0; i <= tpq_pkg::QUEUE_DEPTH; i++)
         send_word(make_word(tpq_pkg::REQ_ENQUEUE, tpq_pkg::LVL_HIGH,
                             tpq_pkg::TASK_BITS'(i * 16'h0F0F)));
      drain_block();

      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0:       phase_limit = 8'd255;
            1:       phase_limit = 8'd0;
            2:       phase_limit = 8'd1;
            3:       phase_limit = 8'd2;
            4:       phase_limit = tpq_pkg::LIMIT_BITS'($urandom_range(3, 254));
            5:       phase_limit = 8'd255;
            default: phase_limit = 8'd0;
         endcase
         set_limit(phase_limit);
         enq_pct   = (phase % 2 == 0) ? 85 : 30;
         fav_level = 2'($urandom_range(0, 2));
         for (int i = 0; i < PHASE_WORDS; i++) begin
            if ((phase == 1 || phase == 4) && i == 10) long_hold_pending = 1'b1;
            send_word(random_word(enq_pct, fav_level, 1'b0));
         end
         drain_block();
      end

      // stopped: enqueues and dequeues refused from here on
      send_word(make_word(tpq_pkg::REQ_STOP, tpq_pkg::LVL_HIGH, 16'h0000));
      send_word(make_word(tpq_pkg::REQ_ENQUEUE, tpq_pkg::LVL_NORMAL, 16'hBEEF));
      send_word(make_word(tpq_pkg::REQ_DEQUEUE, tpq_pkg::LVL_HIGH, 16'h0000));
      send_word(make_word(tpq_pkg::REQ_STOP, tpq_pkg::LVL_LOW, 16'hFFFF));
      send_word(make_word(REQ_IDLE, tpq_pkg::LVL_HIGH, 16'h0000));
      repeat (15) send_word(random_word(50, tpq_pkg::LVL_LOW, 1'b1));
      drain_block();
      repeat (8) @(negedge clock);

      if (mismatch_count == 0 && words_pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
